// ===== rtl/core/hdf_pkg.sv =====
`default_nettype none
package hdf_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_TRUST    = 3'd0;
    localparam logic [2:0] REG_SIZE_MIN = 3'd1;
    localparam logic [2:0] REG_SIZE_MAX = 3'd2;
    localparam logic [2:0] REG_FOCAL_X  = 3'd3;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd4;
    localparam logic [2:0] REG_ALPHA    = 3'd5;

    // depth source codes
    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_SENSOR = 2'd1;
    localparam logic [1:0] MODE_VISUAL = 2'd2;
    localparam logic [1:0] MODE_HOLD   = 2'd3;

    localparam logic [19:0] SIZE_DEFAULT_UM = 20'd80000;
    localparam logic [15:0] START_MIN_MM    = 16'd100;
    localparam logic [13:0] UM_PER_Q4       = 14'd16000;

    // divider operand selects
    typedef enum logic [2:0] {
        DIV_START_W,
        DIV_START_H,
        DIV_VIS,
        DIV_CUR_W,
        DIV_CUR_H,
        DIV_AVG_W,
        DIV_AVG_H
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_START_W,
        ST_START_H,
        ST_VIS,
        ST_CHOOSE,
        ST_CUR_W,
        ST_CUR_H,
        ST_AVG_W,
        ST_AVG_H,
        ST_AVG_LAST,
        ST_FILTER,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     init;
        logic     div_go;
        div_sel_t div_sel;
        logic     wr_start_w;
        logic     wr_start_h;
        logic     wr_vis;
        logic     choose;
        logic     wr_cur_w;
        logic     wr_cur_h;
        logic     wr_avg_w;
        logic     wr_avg_h;
        logic     filt;
        logic     out_inactive;
        logic     out_load;
    } hdf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic is_start;
        logic start_bad;
        logic start_learn;
        logic active;
        logic vis_ok;
        logic sensor_sel;
        logic learn_fy_ok;
        logic cur_w_ok;
    } hdf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/hybrid_depth_fusion.sv =====
// flow: a rejected start or an inactive track goes straight to the result; otherwise a start
// that learns first sizes the target, the visual depth is divided out when possible, and
// a trusted sensor depth refines size; one shared bit-serial divider does up to seven in a row
// throughput: one item at a time; the next item is taken in the cycle the result turns
// valid, and a full output register holds the controller until it drains
// reset: synchronous active-low aresetn restores control and state registers, not the data registers
`default_nettype none
module hybrid_depth_fusion #(
    parameter int COUNT_CAP       = 100,
    parameter int DEPTH_FRAC_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [0:0]  s_tuser,   // command
    input  wire logic [55:0] s_tdata,   // detect_depth_mm, sensor_depth_mm, box_width, box_height
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // final_depth_q8, depth_mode, visual_depth_mm,
                                        // learned_width_um, learned_height_um, target_active
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);
    logic [15:0] trust_reg, fx_reg, fy_reg;
    logic [19:0] smin_reg, smax_reg;
    logic [16:0] alpha_reg;
    hdf_pkg::hdf_cmd_t  cmd;
    hdf_pkg::hdf_stat_t st;
    logic        busy, in_fire;
    logic        mv_reg;
    logic [87:0] md_reg;
    logic [23:0] o_depth;
    logic [1:0]  o_mode;
    logic [15:0] o_vis;
    logic [19:0] o_lw, o_lh;
    logic        o_active;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign in_fire   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trust_reg <= 16'd500;
            smin_reg  <= 20'd30000;
            smax_reg  <= 20'd300000;
            fx_reg    <= 16'd8800;
            fy_reg    <= 16'd8800;
            alpha_reg <= 17'd39322;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hdf_pkg::REG_TRUST:    trust_reg <= cfg_data[15:0];
                hdf_pkg::REG_SIZE_MIN: smin_reg  <= cfg_data;
                hdf_pkg::REG_SIZE_MAX: smax_reg  <= cfg_data;
                hdf_pkg::REG_FOCAL_X:  fx_reg    <= cfg_data[15:0];
                hdf_pkg::REG_FOCAL_Y:  fy_reg    <= cfg_data[15:0];
                hdf_pkg::REG_ALPHA:    alpha_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    hdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .out_free(!mv_reg || m_tready),
        .st      (st),
        .cmd     (cmd),
        .busy    (busy)
    );

    hdf_dp #(
        .COUNT_CAP      (COUNT_CAP),
        .DEPTH_FRAC_BITS(DEPTH_FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .cmd_in   (s_tuser[0]),
        .det_in   (s_tdata[15:0]),
        .sen_in   (s_tdata[31:16]),
        .bw_in    (s_tdata[43:32]),
        .bh_in    (s_tdata[55:44]),
        .trust    (trust_reg),
        .size_min (smin_reg),
        .size_max (smax_reg),
        .focal_x  (fx_reg),
        .focal_y  (fy_reg),
        .alpha_cfg(alpha_reg),
        .o_depth  (o_depth),
        .o_mode   (o_mode),
        .o_vis    (o_vis),
        .o_lw     (o_lw),
        .o_lh     (o_lh),
        .o_active (o_active)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (cmd.out_load) mv_reg <= 1'b1;
        else if (m_tready) mv_reg <= 1'b0;
        if (cmd.out_load)
            md_reg <= {5'd0, o_active, o_lh, o_lw, o_vis, o_mode, o_depth};
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !busy) else $error("load while busy");
    a_out_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid) else $error("result lost");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/hdf_div.sv =====
`default_nettype none
module hdf_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        go,
    input  wire logic [47:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [47:0]      quo
);
    logic [47:0] quo_reg, quo_next;
    logic [47:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [48:0] trial;
    logic [47:0] step_quo, step_rem;

    // one restoring step on the partial remainder
    always_comb begin
        trial = {rem_reg, quo_reg[47]} - {17'd0, den_reg};
        if (!trial[48]) begin
            step_rem = trial[47:0];
            step_quo = {quo_reg[46:0], 1'b1};
        end else begin
            step_rem = {rem_reg[46:0], quo_reg[47]};
            step_quo = {quo_reg[46:0], 1'b0};
        end
    end

    // restoring division, one quotient bit a cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (go) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = step_quo;
            rem_next = step_rem;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (go) den_reg <= den;
    end

    // final quotient is valid while done is high
    assign done = busy_reg && (cnt_reg == 6'd47);
    assign quo  = step_quo;
endmodule
`default_nettype wire

// ===== rtl/core/hdf_ctrl.sv =====
`default_nettype none
module hdf_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic              out_free,
    input  wire hdf_pkg::hdf_stat_t st,
    output hdf_pkg::hdf_cmd_t      cmd,
    output logic                   busy
);
    hdf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= hdf_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    // sequencing of one item
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = hdf_pkg::DIV_VIS;
        unique case (state_reg)
            hdf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = hdf_pkg::ST_START;
                end
            end
            hdf_pkg::ST_START: begin
                if (st.is_start) begin
                    cmd.init = 1'b1;
                    if (st.start_bad) state_next = hdf_pkg::ST_OUT;
                    else if (st.start_learn) begin
                        cmd.div_go  = 1'b1;
                        cmd.div_sel = hdf_pkg::DIV_START_W;
                        state_next  = hdf_pkg::ST_START_W;
                    end else state_next = hdf_pkg::ST_VIS;
                end else if (!st.active) begin
                    cmd.out_inactive = 1'b1;
                    state_next       = hdf_pkg::ST_OUT;
                end else state_next = hdf_pkg::ST_VIS;
            end
            hdf_pkg::ST_START_W: begin
                cmd.div_sel = hdf_pkg::DIV_START_W;
                if (st.div_done) begin
                    cmd.wr_start_w = 1'b1;
                    cmd.div_go     = 1'b1;
                    cmd.div_sel    = hdf_pkg::DIV_START_H;
                    state_next     = hdf_pkg::ST_START_H;
                end
            end
            hdf_pkg::ST_START_H: begin
                cmd.div_sel = hdf_pkg::DIV_START_H;
                if (st.div_done) begin
                    cmd.wr_start_h = 1'b1;
                    state_next     = hdf_pkg::ST_VIS;
                end
            end
            hdf_pkg::ST_VIS: begin
                if (st.vis_ok) begin
                    cmd.div_go = 1'b1;
                    state_next = hdf_pkg::ST_CHOOSE;
                end else state_next = hdf_pkg::ST_CHOOSE;
            end
            hdf_pkg::ST_CHOOSE: begin
                // store the visual depth, then learn only on a trusted sensor depth
                if (!st.vis_ok || st.div_done) begin
                    cmd.wr_vis = st.vis_ok;
                    if (st.sensor_sel && st.learn_fy_ok) begin
                        cmd.div_go  = 1'b1;
                        cmd.div_sel = hdf_pkg::DIV_CUR_W;
                        state_next  = hdf_pkg::ST_CUR_W;
                    end else state_next = hdf_pkg::ST_FILTER;
                end
            end
            hdf_pkg::ST_CUR_W: begin
                cmd.div_sel = hdf_pkg::DIV_CUR_W;
                if (st.div_done) begin
                    cmd.wr_cur_w = 1'b1;
                    cmd.div_go   = 1'b1;
                    cmd.div_sel  = hdf_pkg::DIV_CUR_H;
                    state_next   = hdf_pkg::ST_CUR_H;
                end
            end
            hdf_pkg::ST_CUR_H: begin
                cmd.div_sel = hdf_pkg::DIV_CUR_H;
                if (st.div_done) begin
                    cmd.wr_cur_h = 1'b1;
                    state_next   = hdf_pkg::ST_AVG_W;
                end
            end
            hdf_pkg::ST_AVG_W: begin
                cmd.div_sel = hdf_pkg::DIV_AVG_W;
                if (!st.cur_w_ok) state_next = hdf_pkg::ST_FILTER;
                else begin
                    cmd.div_go = 1'b1;
                    state_next = hdf_pkg::ST_AVG_H;
                end
            end
            hdf_pkg::ST_AVG_H: begin
                cmd.div_sel = hdf_pkg::DIV_AVG_W;
                if (st.div_done) begin
                    cmd.wr_avg_w = 1'b1;
                    cmd.div_go   = 1'b1;
                    cmd.div_sel  = hdf_pkg::DIV_AVG_H;
                    state_next   = hdf_pkg::ST_AVG_LAST;
                end
            end
            hdf_pkg::ST_AVG_LAST: begin
                cmd.div_sel = hdf_pkg::DIV_AVG_H;
                if (st.div_done) begin
                    cmd.wr_avg_h = 1'b1;
                    state_next   = hdf_pkg::ST_FILTER;
                end
            end
            hdf_pkg::ST_FILTER: begin
                cmd.choose = 1'b1;
                cmd.filt   = 1'b1;
                state_next = hdf_pkg::ST_OUT;
            end
            hdf_pkg::ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = hdf_pkg::ST_IDLE;
                end
            end
            default: state_next = hdf_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != hdf_pkg::ST_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/hdf_dp.sv =====
`default_nettype none
module hdf_dp #(
    parameter int COUNT_CAP       = 100,
    parameter int DEPTH_FRAC_BITS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hdf_pkg::hdf_cmd_t cmd,
    output hdf_pkg::hdf_stat_t     st,
    input  wire logic              cmd_in,
    input  wire logic [15:0]       det_in,
    input  wire logic [15:0]       sen_in,
    input  wire logic [11:0]       bw_in,
    input  wire logic [11:0]       bh_in,
    input  wire logic [15:0]       trust,
    input  wire logic [19:0]       size_min,
    input  wire logic [19:0]       size_max,
    input  wire logic [15:0]       focal_x,
    input  wire logic [15:0]       focal_y,
    input  wire logic [16:0]       alpha_cfg,
    output logic [23:0]            o_depth,
    output logic [1:0]             o_mode,
    output logic [15:0]            o_vis,
    output logic [19:0]            o_lw,
    output logic [19:0]            o_lh,
    output logic                   o_active
);
    localparam logic [6:0] CAP = 7'(COUNT_CAP);

    logic        cmd_reg;
    logic [15:0] det_reg, sen_reg;
    logic [11:0] bw_reg, bh_reg;
    logic [23:0] filt_reg, last_reg;
    logic [19:0] lw_reg, lh_reg;
    logic [6:0]  cnt_reg;
    logic [1:0]  mode_reg;
    logic        act_reg;
    logic [15:0] vis_reg;
    logic [47:0] cur_w_reg;
    logic [19:0] cur_h_reg;
    logic [47:0] div_num;
    logic [31:0] div_den;
    logic        div_done;
    logic [47:0] div_quo;
    logic [23:0] chosen;
    logic [16:0] alpha;
    logic [41:0] acc;
    logic [23:0] filt_new;

    // saturating mm to fixed-point depth
    function automatic logic [23:0] mm_to_q(input logic [15:0] mm);
        logic [39:0] w;
        w = {24'd0, mm} << DEPTH_FRAC_BITS;
        return (w > 40'hFFFFFF) ? 24'hFFFFFF : w[23:0];
    endfunction

    function automatic logic [19:0] sat20(input logic [47:0] v);
        return (v > 48'hFFFFF) ? 20'hFFFFF : v[19:0];
    endfunction

    always_comb begin
        div_num = '0;
        div_den = 32'd1;
        unique case (cmd.div_sel)
            hdf_pkg::DIV_START_W: begin
                div_num = 48'(bw_reg) * 48'(det_reg) * 48'(hdf_pkg::UM_PER_Q4);
                div_den = 32'(focal_x);
            end
            hdf_pkg::DIV_START_H: begin
                div_num = 48'(bh_reg) * 48'(det_reg) * 48'(hdf_pkg::UM_PER_Q4);
                div_den = 32'(focal_y);
            end
            hdf_pkg::DIV_VIS: begin
                div_num = 48'(focal_x) * 48'(lw_reg);
                div_den = 32'(bw_reg) * 32'(hdf_pkg::UM_PER_Q4);
            end
            hdf_pkg::DIV_CUR_W: begin
                div_num = 48'(bw_reg) * 48'(sen_reg) * 48'(hdf_pkg::UM_PER_Q4);
                div_den = 32'(focal_x);
            end
            hdf_pkg::DIV_CUR_H: begin
                div_num = 48'(bh_reg) * 48'(sen_reg) * 48'(hdf_pkg::UM_PER_Q4);
                div_den = 32'(focal_y);
            end
            hdf_pkg::DIV_AVG_W: begin
                div_num = 48'(lw_reg) * 48'(cnt_reg) + cur_w_reg;
                div_den = 32'(cnt_reg) + 32'd1;
            end
            hdf_pkg::DIV_AVG_H: begin
                div_num = 48'(lh_reg) * 48'(cnt_reg) + 48'(cur_h_reg);
                div_den = 32'(cnt_reg) + 32'd1;
            end
            default: ;
        endcase
    end

    hdf_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .go     (cmd.div_go),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo)
    );

    // depth choice and exponential filter
    always_comb begin
        if (sen_reg > trust)   chosen = mm_to_q(sen_reg);
        else if (vis_reg != 0) chosen = mm_to_q(vis_reg);
        else                   chosen = last_reg;
        alpha    = (alpha_cfg > 17'd65536) ? 17'd65536 : alpha_cfg;
        acc      = 42'(alpha) * 42'(chosen) + 42'(17'd65536 - alpha) * 42'(filt_reg)
                 + 42'd32768;
        filt_new = (acc[41:16] > 26'hFFFFFF) ? 24'hFFFFFF : acc[39:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
            last_reg <= '0;
            lw_reg   <= hdf_pkg::SIZE_DEFAULT_UM;
            lh_reg   <= hdf_pkg::SIZE_DEFAULT_UM;
            cnt_reg  <= 7'd1;
            mode_reg <= hdf_pkg::MODE_INIT;
            act_reg  <= 1'b0;
            vis_reg  <= '0;
        end else begin
            if (cmd.load) vis_reg <= '0;
            if (cmd.init) begin
                lw_reg   <= hdf_pkg::SIZE_DEFAULT_UM;
                lh_reg   <= hdf_pkg::SIZE_DEFAULT_UM;
                cnt_reg  <= 7'd1;
                mode_reg <= hdf_pkg::MODE_INIT;
                if (bw_reg == 0 || bh_reg == 0) begin
                    filt_reg <= '0;
                    last_reg <= '0;
                    act_reg  <= 1'b0;
                end else begin
                    filt_reg <= mm_to_q(det_reg);
                    last_reg <= mm_to_q(det_reg);
                    act_reg  <= 1'b1;
                end
            end
            if (cmd.wr_start_w)
                lw_reg <= (div_quo == 0) ? hdf_pkg::SIZE_DEFAULT_UM : sat20(div_quo);
            if (cmd.wr_start_h)
                lh_reg <= (div_quo == 0) ? hdf_pkg::SIZE_DEFAULT_UM : sat20(div_quo);
            if (cmd.wr_vis)
                vis_reg <= (div_quo > 48'hFFFF) ? 16'hFFFF : div_quo[15:0];
            if (cmd.wr_avg_w) lw_reg <= sat20(div_quo);
            if (cmd.wr_avg_h) begin
                lh_reg  <= sat20(div_quo);
                cnt_reg <= ({1'b0, cnt_reg} + 8'd1 < {1'b0, CAP}) ? cnt_reg + 7'd1 : CAP;
            end
            if (cmd.filt) begin
                if (sen_reg > trust)   mode_reg <= hdf_pkg::MODE_SENSOR;
                else if (vis_reg != 0) mode_reg <= hdf_pkg::MODE_VISUAL;
                else                   mode_reg <= hdf_pkg::MODE_HOLD;
                filt_reg <= filt_new;
                if (filt_new != 0) last_reg <= filt_new;
            end
        end
        if (cmd.load) begin
            cmd_reg <= cmd_in;
            det_reg <= det_in;
            sen_reg <= sen_in;
            bw_reg  <= bw_in;
            bh_reg  <= bh_in;
        end
        if (cmd.wr_cur_w) cur_w_reg <= div_quo;
        if (cmd.wr_cur_h) cur_h_reg <= sat20(div_quo);
    end

    assign st.div_done    = div_done;
    assign st.is_start    = !cmd_reg;
    assign st.start_bad   = (bw_reg == 0) || (bh_reg == 0);
    assign st.start_learn = (det_reg > hdf_pkg::START_MIN_MM) && (focal_x != 0)
                            && (focal_y != 0);
    assign st.active      = act_reg;
    assign st.vis_ok      = (bw_reg != 0) && (lw_reg != 0) && (focal_x != 0);
    assign st.sensor_sel  = sen_reg > trust;
    assign st.learn_fy_ok = (focal_x != 0) && (focal_y != 0);
    assign st.cur_w_ok    = (cur_w_reg >= 48'(size_min)) && (cur_w_reg <= 48'(size_max));

    assign o_depth  = filt_reg;
    assign o_mode   = mode_reg;
    assign o_vis    = vis_reg;
    assign o_lw     = lw_reg;
    assign o_lh     = lh_reg;
    assign o_active = act_reg;

    logic unused_ok;
    assign unused_ok = cmd.choose ^ cmd.out_inactive ^ cmd.out_load;
endmodule
`default_nettype wire
